// ===== sv/swsr_pkg.sv =====
// Shared types, codes and constants for the single-wire sensor reader.
// Used by swsr_core, swsr_out_buf and single_wire_sensor_reader; no dependencies.
package swsr_pkg;

  // Frame layout: data bytes followed by one checksum byte, sent MSB first
  localparam int FRAME_BITS    = 40;
  localparam int CHECK_BITS    = 8;
  localparam int DATA_BITS     = FRAME_BITS - CHECK_BITS;
  localparam int DATA_BYTES    = (DATA_BITS + 7) / 8;
  localparam int DATA_PAD_BITS = DATA_BYTES * 8;
  localparam int READING_BITS  = 32;
  localparam int BIT_IDX_W     = $clog2(FRAME_BITS + 1);
  localparam int TIMER_W       = 16;

  // Configuration port
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_START_LOW_TIME   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_HIGH_TIME  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RESPONSE_TIMEOUT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_THRESHOLD    = 2'd3;

  localparam logic [15:0] START_LOW_TIME_RST   = 16'd18000;
  localparam logic [7:0]  START_HIGH_TIME_RST  = 8'd40;
  localparam logic [7:0]  RESPONSE_TIMEOUT_RST = 8'd100;
  localparam logic [7:0]  ONE_THRESHOLD_RST    = 8'd50;

  // Line drive codes
  localparam logic [1:0] DRIVE_RELEASE = 2'd0;
  localparam logic [1:0] DRIVE_LOW     = 2'd1;
  localparam logic [1:0] DRIVE_HIGH    = 2'd2;

  // Transaction status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
  localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

  typedef struct packed {
    logic [15:0] start_low_time;
    logic [7:0]  start_high_time;
    logic [7:0]  response_timeout;
    logic [7:0]  one_threshold;
  } cfg_t;

  typedef struct packed {
    logic start_request;
    logic line_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] line_drive;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] humidity_whole;
    logic [7:0] humidity_fraction;
    logic [7:0] temperature_whole;
    logic [7:0] temperature_fraction;
  } result_t;

  // Byte sum modulo 256 of the data bits; a partial top group counts as a byte
  function automatic logic [7:0] byte_sum(input logic [DATA_BITS-1:0] data);
    logic [DATA_PAD_BITS-1:0] padded;
    logic [7:0]               sum;
    padded = DATA_PAD_BITS'(data);
    sum    = '0;
    for (int i = 0; i < DATA_BYTES; i++) begin
      sum = sum + padded[i*8 +: 8];
    end
    return sum;
  endfunction

endpackage

// ===== sv/swsr_out_buf.sv =====
// Two-entry result buffer (output register plus skid register).
// Depends on swsr_pkg for result_t.
module swsr_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  swsr_pkg::result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output swsr_pkg::result_t out_data
);

  logic              skid_valid;
  swsr_pkg::result_t skid_data;
  logic              pop;

  assign pop   = out_valid && out_ready;
  // Room exists whenever the skid entry is free; depends on registers only
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= push_data;
      end else begin
        out_data  <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== sv/swsr_core.sv =====
// Read sequencer: start pulse, response waits, bit timing and checksum check.
// Depends on swsr_pkg for types, codes and frame constants.
module swsr_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  swsr_pkg::in_item_t item,
  input  swsr_pkg::cfg_t     cfg,
  output swsr_pkg::result_t  result
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START_LOW,
    PH_START_HIGH,
    PH_RESP_WAIT,
    PH_RESP_LOW,
    PH_RESP_HIGH,
    PH_BIT_LOW,
    PH_BIT_HIGH
  } phase_t;

  phase_t                              phase, phase_next;
  logic [swsr_pkg::TIMER_W-1:0]        phase_timer, phase_timer_next;
  logic [swsr_pkg::BIT_IDX_W-1:0]      bit_index, bit_index_next;
  logic [swsr_pkg::FRAME_BITS-1:0]     received_bits, received_bits_next;
  logic [swsr_pkg::READING_BITS-1:0]   last_reading, last_reading_next;
  logic [1:0]                          last_status, last_status_next;
  logic                                done;

  logic [swsr_pkg::TIMER_W-1:0]        timer_inc;
  logic [swsr_pkg::TIMER_W:0]          timer_plus1;
  logic                                timed_out;
  logic                                bit_value;
  logic [swsr_pkg::FRAME_BITS-1:0]     frame;
  logic [swsr_pkg::DATA_BITS-1:0]      frame_data;
  logic                                sum_ok;

  always_comb begin
    // Saturating wait counter and the timeout compare
    timer_inc   = (phase_timer == '1) ? phase_timer : phase_timer + 1'b1;
    timed_out   = timer_inc > swsr_pkg::TIMER_W'(cfg.response_timeout);
    timer_plus1 = {1'b0, phase_timer} + 1'b1;
    bit_value   = phase_timer > swsr_pkg::TIMER_W'(cfg.one_threshold);
    frame       = {received_bits[swsr_pkg::FRAME_BITS-2:0], bit_value};
    frame_data  = frame[swsr_pkg::FRAME_BITS-1:swsr_pkg::CHECK_BITS];
    sum_ok      = swsr_pkg::byte_sum(frame_data) == frame[swsr_pkg::CHECK_BITS-1:0];

    phase_next         = phase;
    phase_timer_next   = phase_timer;
    bit_index_next     = bit_index;
    received_bits_next = received_bits;
    last_reading_next  = last_reading;
    last_status_next   = last_status;
    done               = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (item.start_request) begin
          phase_next         = PH_START_LOW;
          phase_timer_next   = '0;
          bit_index_next     = '0;
          received_bits_next = '0;
        end
      end
      PH_START_LOW: begin
        if (timer_plus1 >= (swsr_pkg::TIMER_W + 1)'(cfg.start_low_time)) begin
          phase_next       = PH_START_HIGH;
          phase_timer_next = '0;
        end else begin
          phase_timer_next = timer_plus1[swsr_pkg::TIMER_W-1:0];
        end
      end
      PH_START_HIGH: begin
        if (timer_plus1 >= (swsr_pkg::TIMER_W + 1)'(cfg.start_high_time)) begin
          phase_next       = PH_RESP_WAIT;
          phase_timer_next = '0;
        end else begin
          phase_timer_next = timer_plus1[swsr_pkg::TIMER_W-1:0];
        end
      end
      PH_RESP_WAIT, PH_RESP_HIGH: begin
        if (item.line_level) begin
          phase_timer_next = timer_inc;
          if (timed_out) begin
            done             = 1'b1;
            last_status_next = swsr_pkg::STATUS_TIMEOUT;
            phase_next       = PH_IDLE;
            phase_timer_next = '0;
          end
        end else begin
          phase_next       = (phase == PH_RESP_WAIT) ? PH_RESP_LOW : PH_BIT_LOW;
          phase_timer_next = swsr_pkg::TIMER_W'(1);
        end
      end
      PH_RESP_LOW, PH_BIT_LOW: begin
        if (!item.line_level) begin
          phase_timer_next = timer_inc;
          if (timed_out) begin
            done             = 1'b1;
            last_status_next = swsr_pkg::STATUS_TIMEOUT;
            phase_next       = PH_IDLE;
            phase_timer_next = '0;
          end
        end else begin
          phase_next       = (phase == PH_RESP_LOW) ? PH_RESP_HIGH : PH_BIT_HIGH;
          phase_timer_next = swsr_pkg::TIMER_W'(1);
        end
      end
      PH_BIT_HIGH: begin
        if (item.line_level) begin
          phase_timer_next = timer_inc;
          if (timed_out) begin
            done             = 1'b1;
            last_status_next = swsr_pkg::STATUS_TIMEOUT;
            phase_next       = PH_IDLE;
            phase_timer_next = '0;
          end
        end else begin
          // Falling edge ends the pulse: shift in the decoded bit
          received_bits_next = frame;
          bit_index_next     = bit_index + 1'b1;
          if (bit_index_next >= swsr_pkg::BIT_IDX_W'(swsr_pkg::FRAME_BITS)) begin
            done             = 1'b1;
            phase_next       = PH_IDLE;
            phase_timer_next = '0;
            if (sum_ok) begin
              last_reading_next = swsr_pkg::READING_BITS'(frame_data);
              last_status_next  = swsr_pkg::STATUS_OK;
            end else begin
              last_status_next  = swsr_pkg::STATUS_CHECKSUM;
            end
          end else begin
            phase_next       = PH_BIT_LOW;
            phase_timer_next = swsr_pkg::TIMER_W'(1);
          end
        end
      end
      default: ;
    endcase

    // Result reflects the state after this tick
    unique case (phase_next)
      PH_START_LOW:  result.line_drive = swsr_pkg::DRIVE_LOW;
      PH_START_HIGH: result.line_drive = swsr_pkg::DRIVE_HIGH;
      default:       result.line_drive = swsr_pkg::DRIVE_RELEASE;
    endcase
    result.busy_res             = phase_next != PH_IDLE;
    result.done_res             = done;
    result.status               = last_status_next;
    result.humidity_whole       = last_reading_next[31:24];
    result.humidity_fraction    = last_reading_next[23:16];
    result.temperature_whole    = last_reading_next[15:8];
    result.temperature_fraction = last_reading_next[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      phase_timer   <= '0;
      bit_index     <= '0;
      received_bits <= '0;
      last_reading  <= '0;
      last_status   <= swsr_pkg::STATUS_OK;
    end else if (fire) begin
      phase         <= phase_next;
      phase_timer   <= phase_timer_next;
      bit_index     <= bit_index_next;
      received_bits <= received_bits_next;
      last_reading  <= last_reading_next;
      last_status   <= last_status_next;
    end
  end

endmodule

// ===== sv/single_wire_sensor_reader.sv =====
// An accepted item sits in the input register until the result buffer has room; then it
// enters the sequencer and its result is pushed into the result buffer and offered.
// Throughput: one item per cycle while the buffer has room, set by the single-pass
// sequencer update; a two-entry result buffer keeps input flowing while a result waits.
// Reset (synchronous, active high): sequencer idle, reading and status zero, registers
// back to their defaults, input and result buffers empty.
module single_wire_sensor_reader (
  input  logic                                clk,
  input  logic                                rst,
  // Tick items in
  input  logic                                in_valid,
  output logic                                in_ready,
  input  swsr_pkg::in_item_t                  in_data,
  // Result items out
  output logic                                out_valid,
  input  logic                                out_ready,
  output swsr_pkg::result_t                   out_data,
  // Configuration writes
  input  logic                                cfg_we,
  input  logic [swsr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [swsr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  swsr_pkg::cfg_t     cfg;
  logic               ir_valid;
  swsr_pkg::in_item_t ir_item;
  logic               fire;
  logic               space;
  swsr_pkg::result_t  result;

  // Configuration registers: mask each write to its register width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_low_time   <= swsr_pkg::START_LOW_TIME_RST;
      cfg.start_high_time  <= swsr_pkg::START_HIGH_TIME_RST;
      cfg.response_timeout <= swsr_pkg::RESPONSE_TIMEOUT_RST;
      cfg.one_threshold    <= swsr_pkg::ONE_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swsr_pkg::REG_START_LOW_TIME:   cfg.start_low_time   <= cfg_data;
        swsr_pkg::REG_START_HIGH_TIME:  cfg.start_high_time  <= cfg_data[7:0];
        swsr_pkg::REG_RESPONSE_TIMEOUT: cfg.response_timeout <= cfg_data[7:0];
        swsr_pkg::REG_ONE_THRESHOLD:    cfg.one_threshold    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Advance the held item into the sequencer whenever the result buffer has room.
  // in_ready depends on registers only, so out_ready never reaches in_ready.
  assign fire     = ir_valid && space;
  assign in_ready = !ir_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_ready) begin
      ir_valid <= in_valid;
    end
  end

  // Hold the item until the sequencer takes it
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ir_item <= in_data;
    end
  end

  swsr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (ir_item),
    .cfg    (cfg),
    .result (result)
  );

  swsr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A transaction that ends this tick leaves the sequencer idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    fire && result.done_res |-> !result.busy_res)
    else $error("done reported while still busy");

  // An accepted item is held in the input register on the next cycle
  a_accept_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ir_valid)
    else $error("accepted item lost");

  // A held item that could not advance stays unchanged
  a_stall_stable: assert property (@(posedge clk) disable iff (rst)
    ir_valid && !fire |=> ir_valid && $stable(ir_item))
    else $error("stalled item changed");

  // Offered results carry only defined drive and status codes
  a_codes_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.line_drive == swsr_pkg::DRIVE_RELEASE ||
                   out_data.line_drive == swsr_pkg::DRIVE_LOW ||
                   out_data.line_drive == swsr_pkg::DRIVE_HIGH) &&
                  (out_data.status == swsr_pkg::STATUS_OK ||
                   out_data.status == swsr_pkg::STATUS_TIMEOUT ||
                   out_data.status == swsr_pkg::STATUS_CHECKSUM))
    else $error("undefined code on result");

endmodule

// ===== tb/sensor_read_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for single_wire_sensor_reader: tracks tick, result and register traffic,
// predicts each result and compares it field by field. Depends on swsr_pkg.
module sensor_read_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  swsr_pkg::in_item_t in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  swsr_pkg::result_t  out_data,
  input  logic               cfg_we,
  input  logic [swsr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [swsr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                 mismatches,
  output int                 results_due
);
  import swsr_pkg::*;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_START_LOW, SEQ_START_HIGH, SEQ_RESP_WAIT,
    SEQ_RESP_LOW, SEQ_RESP_HIGH, SEQ_BIT_LOW, SEQ_BIT_HIGH
  } seq_phase_e;

  cfg_t                    regs;
  seq_phase_e              seq_phase;
  logic [TIMER_W-1:0]      seq_timer;
  logic [BIT_IDX_W-1:0]    bits_taken;
  logic [FRAME_BITS-1:0]   frame_bits;
  logic [READING_BITS-1:0] reading;
  logic [1:0]              status_now;
  result_t                 tick_results_due[$];

  initial mismatches = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic bit close_read(input logic [1:0] st);
    status_now = st;
    seq_phase  = SEQ_IDLE;
    seq_timer  = '0;
    return 1'b1;
  endfunction

  // count one more tick at the awaited level; true once the wait is too long
  function automatic bit wait_expired();
    if (seq_timer != '1) seq_timer++;
    return seq_timer > regs.response_timeout;
  endfunction

  function automatic result_t sensor_tick(input in_item_t it);
    bit                   ended;
    logic [DATA_BITS-1:0] payload;
    logic [7:0]           sum;
    result_t              r;
    ended = 1'b0;
    case (seq_phase)
      SEQ_IDLE: if (it.start_request) begin
        seq_phase  = SEQ_START_LOW;
        seq_timer  = '0;
        bits_taken = '0;
        frame_bits = '0;
      end
      SEQ_START_LOW: if (int'(seq_timer) + 1 >= int'(regs.start_low_time)) begin
        seq_phase = SEQ_START_HIGH;
        seq_timer = '0;
      end else seq_timer++;
      SEQ_START_HIGH: if (int'(seq_timer) + 1 >= int'(regs.start_high_time)) begin
        seq_phase = SEQ_RESP_WAIT;
        seq_timer = '0;
      end else seq_timer++;
      SEQ_RESP_WAIT: if (it.line_level) begin
        if (wait_expired()) ended = close_read(STATUS_TIMEOUT);
      end else begin
        seq_phase = SEQ_RESP_LOW;
        seq_timer = TIMER_W'(1);
      end
      SEQ_RESP_LOW: if (!it.line_level) begin
        if (wait_expired()) ended = close_read(STATUS_TIMEOUT);
      end else begin
        seq_phase = SEQ_RESP_HIGH;
        seq_timer = TIMER_W'(1);
      end
      SEQ_RESP_HIGH: if (it.line_level) begin
        if (wait_expired()) ended = close_read(STATUS_TIMEOUT);
      end else begin
        seq_phase = SEQ_BIT_LOW;
        seq_timer = TIMER_W'(1);
      end
      SEQ_BIT_LOW: if (!it.line_level) begin
        if (wait_expired()) ended = close_read(STATUS_TIMEOUT);
      end else begin
        seq_phase = SEQ_BIT_HIGH;
        seq_timer = TIMER_W'(1);
      end
      default: if (it.line_level) begin
        if (wait_expired()) ended = close_read(STATUS_TIMEOUT);
      end else begin
        frame_bits = {frame_bits[FRAME_BITS-2:0], seq_timer > regs.one_threshold};
        bits_taken++;
        if (bits_taken >= BIT_IDX_W'(FRAME_BITS)) begin
          // low byte is the checksum of the bytes above it
          payload = frame_bits[FRAME_BITS-1:CHECK_BITS];
          sum = '0;
          for (int b = 0; b < DATA_BITS; b += 8) sum += 8'(payload >> b);
          if (sum == frame_bits[CHECK_BITS-1:0]) begin
            reading = READING_BITS'(payload);
            ended = close_read(STATUS_OK);
          end else ended = close_read(STATUS_CHECKSUM);
        end else begin
          seq_phase = SEQ_BIT_LOW;
          seq_timer = TIMER_W'(1);
        end
      end
    endcase
    r.line_drive = (seq_phase == SEQ_START_LOW)  ? DRIVE_LOW :
                   (seq_phase == SEQ_START_HIGH) ? DRIVE_HIGH : DRIVE_RELEASE;
    r.busy_res = (seq_phase != SEQ_IDLE);
    r.done_res = ended;
    r.status   = status_now;
    {r.humidity_whole, r.humidity_fraction, r.temperature_whole,
     r.temperature_fraction} = reading;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      regs       = '{START_LOW_TIME_RST, START_HIGH_TIME_RST, RESPONSE_TIMEOUT_RST,
                     ONE_THRESHOLD_RST};
      seq_phase  = SEQ_IDLE;
      seq_timer  = '0;
      bits_taken = '0;
      frame_bits = '0;
      reading    = '0;
      status_now = STATUS_OK;
      tick_results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_LOW_TIME:   regs.start_low_time   = cfg_data;
          REG_START_HIGH_TIME:  regs.start_high_time  = cfg_data[7:0];
          REG_RESPONSE_TIMEOUT: regs.response_timeout = cfg_data[7:0];
          REG_ONE_THRESHOLD:    regs.one_threshold    = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (tick_results_due.size() == 0) begin
          report_mismatch("result with nothing due");
        end else begin
          want = tick_results_due.pop_front();
          check_field("line_drive", out_data.line_drive, want.line_drive);
          check_field("busy_res", out_data.busy_res, want.busy_res);
          check_field("done_res", out_data.done_res, want.done_res);
          check_field("status", out_data.status, want.status);
          check_field("humidity_whole", out_data.humidity_whole, want.humidity_whole);
          check_field("humidity_fraction", out_data.humidity_fraction,
                      want.humidity_fraction);
          check_field("temperature_whole", out_data.temperature_whole,
                      want.temperature_whole);
          check_field("temperature_fraction", out_data.temperature_fraction,
                      want.temperature_fraction);
        end
      end
      if (in_valid && in_ready) tick_results_due.push_back(sensor_tick(in_data));
    end
    results_due <= tick_results_due.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the single_wire_sensor_reader testbench: clock, reset, sensor-side tick stimulus,
// register settings and the verdict. Depends on swsr_pkg and sensor_read_checker.
module testbench;
  import swsr_pkg::*;

  localparam int GAP_PCT   = 47;  // idle share of one side when only it idles
  localparam int BOTH_PCT  = 24;  // idle share of each side when both idle
  localparam int HOLD_OFF  = 60;  // cycles of the long receiver hold-off

  typedef enum {READ_GOOD, READ_BAD_SUM, READ_TIMEOUT, READ_NOISE} read_kind_e;
  typedef enum {STG_NONE, STG_RESP_WAIT, STG_RESP_LOW, STG_RESP_HIGH,
                STG_BIT_LOW, STG_BIT_HIGH} wait_stage_e;

  typedef struct {
    cfg_t settings;
    int   send_pct;
    int   recv_pct;
    int   budget;
  } phase_plan_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  in_item_t in_data;
  logic     out_valid;
  logic     out_ready;
  result_t  out_data;
  logic     cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatch_total;
  int results_due;

  cfg_t        cur_cfg;        // what the block has been told, for shaping sensor timing
  int          sent_items = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off_asks = 0;
  phase_plan_t plan[10];

  single_wire_sensor_reader uut (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  sensor_read_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_data,
    .mismatches(mismatch_total), .results_due(results_due)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  // Result side: stall at the phase's rate; on request hold off for a long stretch
  // while the sender keeps offering ticks, so the block backs up and drops in_ready.
  initial begin
    int hold_off_seen;
    int stall_left;
    hold_off_seen = 0;
    stall_left    = 0;
    out_ready     = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_asks != hold_off_seen) begin
        hold_off_seen = hold_off_asks;
        stall_left    = HOLD_OFF;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic int min_of(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  function automatic cfg_t settings(input int lo, input int hi, input int tmo, input int thr);
    return '{start_low_time: 16'(lo), start_high_time: 8'(hi),
             response_timeout: 8'(tmo), one_threshold: 8'(thr)};
  endfunction

  // Ticks the block spends in its two start phases (a zero length still takes one tick)
  function automatic int start_span();
    return ((cur_cfg.start_low_time == 0) ? 1 : int'(cur_cfg.start_low_time)) +
           ((cur_cfg.start_high_time == 0) ? 1 : int'(cur_cfg.start_high_time));
  endfunction

  // Longest wait that still passes
  function automatic int wait_limit();
    return (cur_cfg.response_timeout == 0) ? 1 : int'(cur_cfg.response_timeout);
  endfunction

  // Mostly short waits, now and then anything up to the limit
  function automatic int pick_len(input int lim);
    if ($urandom_range(99) < 85) return $urandom_range(1, min_of(lim, 4));
    return $urandom_range(1, lim);
  endfunction

  // High pulse for one data bit; hug the threshold now and then
  function automatic int pulse_len(input logic one, input int lim);
    int thr;
    int z;
    thr = int'(cur_cfg.one_threshold);
    if (one) begin
      if (thr + 1 > lim) return pick_len(lim);
      if ($urandom_range(3) == 0) return thr + 1;
      return $urandom_range(thr + 1, min_of(lim, thr + 3));
    end
    if (thr == 0) return 1;
    z = min_of(thr, lim);
    if ($urandom_range(3) == 0) return z;
    return $urandom_range(1, min_of(z, 4));
  endfunction

  // Offer one tick; hold it until taken
  task automatic send_tick(input logic start, input logic level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{start_request: start, line_level: level};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
  endtask

  // Stop offering and wait until every result has come back
  task automatic wait_results_in();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Write all four registers; junk in the upper byte of the 8-bit ones must be dropped
  task automatic apply_settings(input cfg_t c);
    write_reg(REG_START_LOW_TIME, c.start_low_time);
    write_reg(REG_START_HIGH_TIME, {8'($urandom), c.start_high_time});
    write_reg(REG_RESPONSE_TIMEOUT, {8'($urandom), c.response_timeout});
    write_reg(REG_ONE_THRESHOLD, {8'($urandom), c.one_threshold});
    cfg_we  <= 1'b0;
    cur_cfg = c;
  endtask

  // Start tick, then filler through both start phases; start requests while busy
  // are scattered in and must be ignored
  task automatic start_read();
    send_tick(1'b1, 1'($urandom));
    repeat (start_span()) send_tick(1'($urandom), 1'($urandom));
  endtask

  // Hold the line at one level: a passing length, or one tick past the limit
  task automatic hold_level(input logic level, input bit overrun, input int lim);
    int n;
    n = overrun ? lim + 1 : pick_len(lim);
    repeat (n) send_tick(1'($urandom), level);
  endtask

  // One read as the sensor would answer it: good frame, bad checksum, a stall in
  // one of the wait phases, or line noise followed by a flush back to idle
  task automatic sensor_read();
    read_kind_e  kind;
    wait_stage_e stall_at;
    int          roll;
    int          lim;
    int          fail_bit;
    logic [31:0] data;
    logic [7:0]  chk;
    logic [39:0] frame;
    lim  = wait_limit();
    roll = $urandom_range(99);
    kind = (roll < 60) ? READ_GOOD : (roll < 72) ? READ_BAD_SUM :
           (roll < 87) ? READ_TIMEOUT : READ_NOISE;
    stall_at = STG_NONE;
    if (kind == READ_TIMEOUT) stall_at = wait_stage_e'($urandom_range(1, 5));
    fail_bit = $urandom_range(0, FRAME_BITS - 1);

    roll = $urandom_range(9);
    data = (roll == 0) ? 32'h0 : (roll == 1) ? 32'hFFFF_FFFF : $urandom;
    chk  = data[31:24] + data[23:16] + data[15:8] + data[7:0];
    if (kind == READ_BAD_SUM) chk ^= 8'($urandom_range(1, 255));
    frame = {data, chk};

    start_read();
    if (kind == READ_NOISE) begin
      repeat ($urandom_range(10, 150)) send_tick(1'($urandom), 1'($urandom));
      // a long high stretch ends any wait phase, so the block is idle afterwards
      repeat (start_span() + 2 * lim + 4) send_tick(1'b0, 1'b1);
      return;
    end

    // response: line still high, then low, then high
    if (stall_at == STG_RESP_WAIT) begin
      repeat (int'(cur_cfg.response_timeout) + 1) send_tick(1'($urandom), 1'b1);
      return;
    end
    repeat ($urandom_range(0, min_of(int'(cur_cfg.response_timeout), 3)))
      send_tick(1'($urandom), 1'b1);
    hold_level(1'b0, stall_at == STG_RESP_LOW, lim);
    if (stall_at == STG_RESP_LOW) return;
    hold_level(1'b1, stall_at == STG_RESP_HIGH, lim);
    if (stall_at == STG_RESP_HIGH) return;

    // data bits, MSB first: low gap, then a high pulse timed against the threshold
    for (int i = 0; i < FRAME_BITS; i++) begin
      hold_level(1'b0, stall_at == STG_BIT_LOW && i == fail_bit, lim);
      if (stall_at == STG_BIT_LOW && i == fail_bit) return;
      if (stall_at == STG_BIT_HIGH && i == fail_bit) begin
        repeat (lim + 1) send_tick(1'($urandom), 1'b1);
        return;
      end
      repeat (pulse_len(frame[FRAME_BITS - 1 - i], lim)) send_tick(1'($urandom), 1'b1);
    end
    // falling edge after the last pulse closes the frame
    send_tick(1'($urandom), 1'b0);
  endtask

  initial begin
    int first_item;
    int reads;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cur_cfg   = settings(START_LOW_TIME_RST, START_HIGH_TIME_RST,
                         RESPONSE_TIMEOUT_RST, ONE_THRESHOLD_RST);

    // Short start phases keep each read to a few hundred ticks; thresholds and
    // timeouts sweep their extremes, each setting with its own idling pattern
    plan[0] = '{settings(3, 2, 6, 2),       0,        0,        1};
    plan[1] = '{settings(1, 1, 4, 1),       GAP_PCT,  0,        1};
    plan[2] = '{settings(2, 9, 8, 254),     0,        GAP_PCT,  1};
    plan[3] = '{settings(7, 1, 1, 0),       BOTH_PCT, BOTH_PCT, 150};
    plan[4] = '{settings(2, 3, 10, 5),      0,        GAP_PCT,  1};
    plan[5] = '{settings(0, 0, 3, 1),       BOTH_PCT, BOTH_PCT, 1};
    plan[6] = '{settings(4, 1, 8, 3),       0,        0,        1};
    plan[7] = '{settings(1, 2, 5, 2),       GAP_PCT,  0,        1};
    plan[8] = '{settings(1, 1, 2, 255),     BOTH_PCT, BOTH_PCT, 150};
    plan[9] = '{settings(2, 1, 3, 0),       0,        GAP_PCT,  1};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle ticks at both line levels, then with every register at zero a stall
    // in each response phase and before the first bit, with start requests while busy mixed in
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    wait_results_in();
    apply_settings(settings(0, 0, 0, 0));
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    start_read();
    send_tick(1'b0, 1'b1);                          // no response at all
    start_read();
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);                          // response low too long
    start_read();
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);                          // response high too long
    start_read();
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);                          // gap before first bit too long

    foreach (plan[p]) begin
      wait_results_in();
      apply_settings(plan[p].settings);
      send_idle_pct  = plan[p].send_pct;
      recv_stall_pct = plan[p].recv_pct;
      first_item     = sent_items;
      reads          = 0;
      while (sent_items - first_item < plan[p].budget) begin
        if (reads == 0) hold_off_asks++;      // back up the block mid-read
        sensor_read();
        reads++;
        if (reads == 2) wait_results_in();    // let it run dry before the next read
        repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom));
      end
    end

    wait_results_in();
    repeat (10) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/swsr_pkg.sv
sv/swsr_out_buf.sv
sv/swsr_core.sv
sv/single_wire_sensor_reader.sv
tb/sensor_read_checker.sv
tb/testbench.sv
